// ===== design/tchc_pkg.sv =====
`default_nettype none

package tchc_pkg;

  // Default sizing of the facet table and of the coordinate datapath.
  localparam int unsigned MaxFacetsDefault = 1024;
  localparam int unsigned CoordBitsDefault = 20;

  // Fixed port widths of the transaction fields.
  localparam int unsigned FieldBits = 20;
  localparam int unsigned OpBits    = 2;
  localparam int unsigned ClassBits = 2;
  localparam int unsigned MaskBits  = 4;
  localparam int unsigned CountBits = 3;

  // The stored normal is split here so that each multiplier operand stays near 22 bits.
  localparam int unsigned SplitBits = 22;

  // Operation codes of an input transaction.
  typedef enum logic [OpBits-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_TEST  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Cell classification codes.
  localparam logic [ClassBits-1:0] ClassInside  = 2'd0;
  localparam logic [ClassBits-1:0] ClassOutside = 2'd1;
  localparam logic [ClassBits-1:0] ClassMixed   = 2'd2;

endpackage

`default_nettype wire

// ===== design/tchc_dot_pipe.sv =====
`default_nettype none

// Three-stage pipeline that evaluates the sign of (p - ref) . n for one
// facet word per cycle and flags the facets that put the point outside.
module tchc_dot_pipe #(
  parameter int unsigned COORD_BITS = tchc_pkg::CoordBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          flush_i,
  input  wire logic                          valid_i,
  input  wire logic [3*(2*COORD_BITS+3)+3*COORD_BITS-1:0] word_i,
  input  wire logic signed [COORD_BITS-1:0]  p_x_i,
  input  wire logic signed [COORD_BITS-1:0]  p_y_i,
  input  wire logic signed [COORD_BITS-1:0]  p_z_i,
  output logic                               hit_o,
  output logic                               busy_o
);

  localparam int unsigned Cb = COORD_BITS;
  localparam int unsigned Nw = 2 * Cb + 3;
  localparam int unsigned Dw = Cb + 1;
  localparam int unsigned Sb = tchc_pkg::SplitBits;
  localparam int unsigned Hw = Nw - Sb;
  localparam int unsigned Lw = Sb + 1;
  localparam int unsigned Sw = 3 * Cb + 8;

  logic signed [Nw-1:0] n_w [3];
  logic signed [Cb-1:0] r_w [3];
  logic signed [Cb-1:0] p_w [3];

  logic                 v2_q, v3_q, v4_q;
  logic signed [Dw-1:0] d_q [3];
  logic signed [Nw-1:0] n_q [3];
  logic signed [Dw+Hw-1:0] phi_q [3];
  logic signed [Dw+Lw-1:0] plo_q [3];
  logic signed [Sw-1:0] hs_q, ls_q;
  logic signed [Sw-1:0] total;

  // Unpack the facet word: normals on top, reference vertex below.
  assign n_w[0] = word_i[3*Nw+3*Cb-1 -: Nw];
  assign n_w[1] = word_i[2*Nw+3*Cb-1 -: Nw];
  assign n_w[2] = word_i[Nw+3*Cb-1 -: Nw];
  assign r_w[0] = word_i[3*Cb-1 -: Cb];
  assign r_w[1] = word_i[2*Cb-1 -: Cb];
  assign r_w[2] = word_i[Cb-1 -: Cb];
  assign p_w[0] = p_x_i;
  assign p_w[1] = p_y_i;
  assign p_w[2] = p_z_i;

  // Valid bits of the stages; a hit flushes the rest of the scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (flush_i) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v2_q <= valid_i;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Difference, split products, and partial sums, one stage each.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      d_q[k]   <= Dw'(p_w[k]) - Dw'(r_w[k]);
      n_q[k]   <= n_w[k];
      phi_q[k] <= d_q[k] * $signed(n_q[k][Nw-1:Sb]);
      plo_q[k] <= d_q[k] * $signed({1'b0, n_q[k][Sb-1:0]});
    end
    hs_q <= Sw'(phi_q[0]) + Sw'(phi_q[1]) + Sw'(phi_q[2]);
    ls_q <= Sw'(plo_q[0]) + Sw'(plo_q[1]) + Sw'(plo_q[2]);
  end

  // Recombine the high and low halves; a negative total means outside.
  assign total  = (hs_q <<< Sb) + ls_q;
  assign hit_o  = v4_q && total[Sw-1];
  assign busy_o = v2_q || v3_q || v4_q;

endmodule

`default_nettype wire

// ===== design/tetra_cell_hull_classifier.sv =====
`default_nettype none

// Channel   Direction  Handshake               Fields
// command   in         start_i high, busy_o low operation_i, coord_x_i/y_i/z_i
// result    out        done_o, one cycle        cell_class_o, outside_mask_o,
//                                               outside_count_o, hull_overflow_o
//
// A clear, a first or second hull vertex, and an unused code leave the block idle.
// A third hull vertex is accepted, then passes through the cross product
// multipliers (ST_LOAD_MUL) and is written to the facet memory (ST_LOAD_WR).
// A test vertex scans the facet table and stops at the first outside facet:
// the facet memory delivers one facet per cycle into a three-stage dot product
// pipeline. With an empty table the scan ends at once.
// Reset is asynchronous and needs no clearing pass. The result receiver
// cannot stall; done_o pulses for one cycle.
module tetra_cell_hull_classifier #(
  parameter int unsigned MAX_FACETS = tchc_pkg::MaxFacetsDefault,
  parameter int unsigned COORD_BITS = tchc_pkg::CoordBitsDefault
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic [tchc_pkg::OpBits-1:0]        operation_i,
  input  wire logic signed [tchc_pkg::FieldBits-1:0] coord_x_i,
  input  wire logic signed [tchc_pkg::FieldBits-1:0] coord_y_i,
  input  wire logic signed [tchc_pkg::FieldBits-1:0] coord_z_i,
  output logic                                    done_o,
  output logic [tchc_pkg::ClassBits-1:0]          cell_class_o,
  output logic [tchc_pkg::MaskBits-1:0]           outside_mask_o,
  output logic [tchc_pkg::CountBits-1:0]          outside_count_o,
  output logic                                    hull_overflow_o
);

  localparam int unsigned Cb = COORD_BITS;
  localparam int unsigned Nw = 2 * Cb + 3;
  localparam int unsigned Pw = 2 * Cb + 2;
  localparam int unsigned Dw = Cb + 1;
  localparam int unsigned Ww = 3 * Nw + 3 * Cb;
  localparam int unsigned Aw = (MAX_FACETS > 1) ? $clog2(MAX_FACETS) : 1;
  localparam int unsigned Cw = $clog2(MAX_FACETS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD_MUL,
    ST_LOAD_WR,
    ST_SCAN
  } state_e;

  state_e state_q;

  logic signed [Cb-1:0] p_q [3];
  logic signed [Cb-1:0] pa_q [3];
  logic signed [Cb-1:0] pb_q [3];
  logic [1:0]           pend_cnt_q;
  logic [Cw-1:0]        facet_cnt_q;
  logic [Cw-1:0]        issue_q;
  logic [1:0]           vidx_q;
  logic [tchc_pkg::MaskBits-1:0] mask_q;
  logic                 ovf_q;
  logic                 rd_valid_q;
  logic [Ww-1:0]        rdata_q;
  logic [Ww-1:0]        mem [MAX_FACETS];
  logic signed [Pw-1:0] prod_q [6];

  logic                 accept;
  logic signed [Cb-1:0] p_in [3];
  logic signed [Dw-1:0] u [3];
  logic signed [Dw-1:0] v [3];
  logic signed [Nw-1:0] n_new [3];
  logic                 issuing;
  logic                 hit;
  logic                 dot_busy;
  logic                 scan_done;
  logic [tchc_pkg::MaskBits-1:0] mask_new;
  logic [tchc_pkg::CountBits-1:0] cnt_new;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE);

  // Only the low COORD_BITS of each coordinate take part.
  assign p_in[0] = coord_x_i[Cb-1:0];
  assign p_in[1] = coord_y_i[Cb-1:0];
  assign p_in[2] = coord_z_i[Cb-1:0];

  // Edge vectors of the facet: u = c - b, v = b - a.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u[k] = Dw'(p_q[k]) - Dw'(pb_q[k]);
      v[k] = Dw'(pb_q[k]) - Dw'(pa_q[k]);
    end
  end

  // Cross product from the registered partial products.
  assign n_new[0] = Nw'(prod_q[0]) - Nw'(prod_q[1]);
  assign n_new[1] = Nw'(prod_q[2]) - Nw'(prod_q[3]);
  assign n_new[2] = Nw'(prod_q[4]) - Nw'(prod_q[5]);

  // Scan issue and completion.
  assign issuing   = (state_q == ST_SCAN) && (issue_q < facet_cnt_q) && !hit;
  assign scan_done = (state_q == ST_SCAN) &&
                     (hit || (!issuing && !rd_valid_q && !dot_busy));
  assign mask_new  = mask_q | (hit ? (tchc_pkg::MaskBits'(1) << vidx_q)
                                   : tchc_pkg::MaskBits'(0));
  assign cnt_new   = tchc_pkg::CountBits'($countones(mask_new));

  // Facet memory: written on the last load cycle, read once per scan cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD_WR) begin
      mem[facet_cnt_q[Aw-1:0]] <= {n_new[0], n_new[1], n_new[2],
                                   pb_q[0], pb_q[1], pb_q[2]};
    end
    rdata_q <= mem[issue_q[Aw-1:0]];
  end

  // Cross product multipliers.
  always_ff @(posedge clk_i) begin
    prod_q[0] <= u[1] * v[2];
    prod_q[1] <= u[2] * v[1];
    prod_q[2] <= u[2] * v[0];
    prod_q[3] <= u[0] * v[2];
    prod_q[4] <= u[0] * v[1];
    prod_q[5] <= u[1] * v[0];
  end

  // Control state machine with the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      pend_cnt_q      <= 2'd0;
      facet_cnt_q     <= '0;
      issue_q         <= '0;
      vidx_q          <= 2'd0;
      mask_q          <= '0;
      ovf_q           <= 1'b0;
      rd_valid_q      <= 1'b0;
      done_o          <= 1'b0;
      cell_class_o    <= tchc_pkg::ClassInside;
      outside_mask_o  <= '0;
      outside_count_o <= '0;
      hull_overflow_o <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        p_q[k]  <= '0;
        pa_q[k] <= '0;
        pb_q[k] <= '0;
      end
    end else begin
      // The result strobe follows the end of the fourth scan of a cell.
      done_o <= scan_done && (vidx_q == 2'd3);
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (tchc_pkg::op_e'(operation_i))
              tchc_pkg::OP_CLEAR: begin
                facet_cnt_q <= '0;
                pend_cnt_q  <= 2'd0;
                ovf_q       <= 1'b0;
              end
              tchc_pkg::OP_LOAD: begin
                if (pend_cnt_q == 2'd0) begin
                  for (int k = 0; k < 3; k++) pa_q[k] <= p_in[k];
                  pend_cnt_q <= 2'd1;
                end else if (pend_cnt_q == 2'd1) begin
                  for (int k = 0; k < 3; k++) pb_q[k] <= p_in[k];
                  pend_cnt_q <= 2'd2;
                end else begin
                  pend_cnt_q <= 2'd0;
                  if (facet_cnt_q == Cw'(MAX_FACETS)) begin
                    ovf_q <= 1'b1;
                  end else begin
                    for (int k = 0; k < 3; k++) p_q[k] <= p_in[k];
                    state_q <= ST_LOAD_MUL;
                  end
                end
              end
              tchc_pkg::OP_TEST: begin
                for (int k = 0; k < 3; k++) p_q[k] <= p_in[k];
                issue_q <= '0;
                state_q <= ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_LOAD_MUL: begin
          state_q <= ST_LOAD_WR;
        end
        ST_LOAD_WR: begin
          facet_cnt_q <= facet_cnt_q + Cw'(1);
          state_q     <= ST_IDLE;
        end
        ST_SCAN: begin
          // Nothing is issued in the cycle that ends the scan.
          rd_valid_q <= issuing;
          if (issuing) begin
            issue_q <= issue_q + Cw'(1);
          end
          if (scan_done) begin
            vidx_q     <= vidx_q + 2'd1;
            state_q    <= ST_IDLE;
            if (vidx_q == 2'd3) begin
              mask_q          <= '0;
              outside_mask_o  <= mask_new;
              outside_count_o <= cnt_new;
              hull_overflow_o <= ovf_q;
              if (cnt_new == '0) begin
                cell_class_o <= tchc_pkg::ClassInside;
              end else if (cnt_new == tchc_pkg::CountBits'(4)) begin
                cell_class_o <= tchc_pkg::ClassOutside;
              end else begin
                cell_class_o <= tchc_pkg::ClassMixed;
              end
            end else begin
              mask_q <= mask_new;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Dot product pipeline behind the memory read register.
  tchc_dot_pipe #(
    .COORD_BITS(COORD_BITS)
  ) u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (hit),
    .valid_i (rd_valid_q && !hit),
    .word_i  (rdata_q),
    .p_x_i   (p_q[0]),
    .p_y_i   (p_q[1]),
    .p_z_i   (p_q[2]),
    .hit_o   (hit),
    .busy_o  (dot_busy)
  );

  // A result only follows the end of a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_SCAN))
    else $error("result without a finished scan");

  // The count always matches the mask it reports.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (outside_count_o == tchc_pkg::CountBits'($countones(outside_mask_o))))
    else $error("outside count does not match mask");

  // The facet table never grows past its capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    facet_cnt_q <= Cw'(MAX_FACETS))
    else $error("facet count beyond capacity");

  // No facet is flagged outside while the block is not scanning.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> (state_q == ST_SCAN))
    else $error("facet hit outside a scan");

endmodule

`default_nettype wire

// ===== tb/tetra_cell_hull_classifier_tb.sv =====
`timescale 1ns / 100ps

module tetra_cell_hull_classifier_tb;

  localparam int unsigned Facets = tchc_pkg::MaxFacetsDefault;
  localparam int RandItems = 530;
  localparam int QuietTail = 60;
  localparam int CoordMax = 524287;
  localparam int CoordMin = -524288;

  typedef struct packed {
    logic [tchc_pkg::ClassBits-1:0] cls;
    logic [tchc_pkg::MaskBits-1:0]  mask;
    logic [tchc_pkg::CountBits-1:0] cnt;
    logic                           ovf;
  } verdict_t;

  typedef struct {
    tchc_pkg::op_e op;
    int            x;
    int            y;
    int            z;
    bit            typed;
    verdict_t      v;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic [tchc_pkg::OpBits-1:0] operation_i;
  logic signed [tchc_pkg::FieldBits-1:0] coord_x_i, coord_y_i, coord_z_i;
  logic done_o;
  logic [tchc_pkg::ClassBits-1:0] cell_class_o;
  logic [tchc_pkg::MaskBits-1:0] outside_mask_o;
  logic [tchc_pkg::CountBits-1:0] outside_count_o;
  logic hull_overflow_o;

  tetra_cell_hull_classifier dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .operation_i,
    .coord_x_i, .coord_y_i, .coord_z_i, .done_o, .cell_class_o,
    .outside_mask_o, .outside_count_o, .hull_overflow_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow of the facet table and the cell progress.
  longint hull_nx[Facets];
  longint hull_ny[Facets];
  longint hull_nz[Facets];
  int hull_rx[Facets];
  int hull_ry[Facets];
  int hull_rz[Facets];
  int facet_total;
  int pend_cnt;
  int pend_v[2][3];
  int cell_idx;
  logic [3:0] cell_mask;
  bit ovf_flag;

  verdict_t verdict_q[$];
  int errors = 0;
  row_t rows[$];

  // A vertex is outside when the exact (p - ref) . normal is negative for any facet.
  function automatic bit vertex_outside(int px, int py, int pz);
    logic signed [127:0] dx, dy, dz, nx, ny, nz, dot;
    for (int j = 0; j < facet_total; j++) begin
      dx = px - hull_rx[j];
      dy = py - hull_ry[j];
      dz = pz - hull_rz[j];
      nx = hull_nx[j];
      ny = hull_ny[j];
      nz = hull_nz[j];
      dot = dx * nx + dy * ny + dz * nz;
      if (dot < 0) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the shadow state by one accepted command; returns 1 when a verdict is due.
  function automatic bit classify_step(tchc_pkg::op_e op, int x, int y, int z,
                                       output verdict_t v);
    longint ux, uy, uz, vx, vy, vz;
    int cnt;
    v = '0;
    case (op)
      tchc_pkg::OP_CLEAR: begin
        facet_total = 0;
        pend_cnt = 0;
        ovf_flag = 1'b0;
      end
      tchc_pkg::OP_LOAD: begin
        if (pend_cnt < 2) begin
          pend_v[pend_cnt] = '{x, y, z};
          pend_cnt++;
        end else begin
          pend_cnt = 0;
          if (facet_total >= Facets) begin
            ovf_flag = 1'b1;
          end else begin
            ux = x - pend_v[1][0];
            uy = y - pend_v[1][1];
            uz = z - pend_v[1][2];
            vx = pend_v[1][0] - pend_v[0][0];
            vy = pend_v[1][1] - pend_v[0][1];
            vz = pend_v[1][2] - pend_v[0][2];
            hull_nx[facet_total] = uy * vz - uz * vy;
            hull_ny[facet_total] = uz * vx - ux * vz;
            hull_nz[facet_total] = ux * vy - uy * vx;
            hull_rx[facet_total] = pend_v[1][0];
            hull_ry[facet_total] = pend_v[1][1];
            hull_rz[facet_total] = pend_v[1][2];
            facet_total++;
          end
        end
      end
      tchc_pkg::OP_TEST: begin
        if (vertex_outside(x, y, z)) cell_mask[cell_idx] = 1'b1;
        cell_idx = (cell_idx + 1) % 4;
        if (cell_idx == 0) begin
          cnt = $countones(cell_mask);
          v.cls = (cnt == 0) ? tchc_pkg::ClassInside :
                  (cnt == 4) ? tchc_pkg::ClassOutside : tchc_pkg::ClassMixed;
          v.mask = cell_mask;
          v.cnt = tchc_pkg::CountBits'(cnt);
          v.ovf = ovf_flag;
          cell_mask = '0;
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Presents one command and waits for it to be taken.
  task automatic issue(tchc_pkg::op_e op, int x, int y, int z, bit typed, verdict_t tv);
    verdict_t v;
    start_i <= 1'b1;
    operation_i <= op;
    coord_x_i <= x[tchc_pkg::FieldBits-1:0];
    coord_y_i <= y[tchc_pkg::FieldBits-1:0];
    coord_z_i <= z[tchc_pkg::FieldBits-1:0];
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (classify_step(op, x, y, z, v)) verdict_q.insert(verdict_q.size(), typed ? tv : v);
  endtask

  // Random idle burst on the command side.
  task automatic maybe_idle(bit allowed);
    int n;
    if (allowed && $urandom_range(0, 99) < 25) begin
      n = $urandom_range(1, 11);
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic add_row(tchc_pkg::op_e op, int x, int y, int z, bit typed = 0,
                         logic [tchc_pkg::ClassBits-1:0] cls = '0,
                         logic [tchc_pkg::MaskBits-1:0] mask = '0,
                         logic [tchc_pkg::CountBits-1:0] cnt = '0, bit ovf = 0);
    row_t r;
    r.op = op;
    r.x = x;
    r.y = y;
    r.z = z;
    r.typed = typed;
    r.v = '{cls, mask, cnt, ovf};
    rows.insert(rows.size(), r);
  endtask

  function automatic int rand_coord();
    if ($urandom_range(0, 99) < 75) return $urandom_range(0, 2047) - 1024;
    return $signed($urandom() << 12) >>> 12;
  endfunction

  task automatic report(string what, verdict_t e, verdict_t a);
    errors++;
    if (errors <= 10)
      $display("%0t: %s: expected class %0d mask %h count %0d ovf %0d, %s %0d %s %h %s %0d %s %0d",
               $realtime, what, e.cls, e.mask, e.cnt, e.ovf,
               "got class", a.cls, "mask", a.mask, "count", a.cnt, "ovf", a.ovf);
  endtask

  // Every verdict transaction is compared with the oldest expectation.
  always @(posedge clk_i) begin
    verdict_t got, want;
    if (rst_ni && done_o === 1'b1) begin
      got = '{cell_class_o, outside_mask_o, outside_count_o, hull_overflow_o};
      if (verdict_q.size() == 0) begin
        report("unexpected verdict", '0, got);
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) report("verdict mismatch", want, got);
      end
    end
  end

  initial begin
    tchc_pkg::op_e op;
    int r, n;
    facet_total = 0;
    pend_cnt = 0;
    pend_v = '{'{0, 0, 0}, '{0, 0, 0}};
    cell_idx = 0;
    cell_mask = '0;
    ovf_flag = 1'b0;
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    operation_i <= tchc_pkg::OP_NONE;
    coord_x_i <= '0;
    coord_y_i <= '0;
    coord_z_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table at the coordinate extremes, then an ignored code.
    add_row(tchc_pkg::OP_TEST, CoordMax, CoordMax, CoordMax);
    add_row(tchc_pkg::OP_TEST, CoordMin, CoordMin, CoordMin);
    add_row(tchc_pkg::OP_TEST, CoordMax, CoordMin, 0);
    add_row(tchc_pkg::OP_TEST, CoordMin, CoordMax, -1, 1, tchc_pkg::ClassInside,
            4'h0, 3'd0, 0);
    add_row(tchc_pkg::OP_NONE, CoordMax, CoordMin, CoordMax);
    // Floor facet: points with positive z are outside.
    add_row(tchc_pkg::OP_LOAD, 0, 0, 0);
    add_row(tchc_pkg::OP_LOAD, 256, 0, 0);
    add_row(tchc_pkg::OP_LOAD, 0, 256, 0);
    add_row(tchc_pkg::OP_TEST, 5, 5, 1);
    add_row(tchc_pkg::OP_TEST, CoordMin, CoordMax, 256);
    add_row(tchc_pkg::OP_TEST, 0, 0, CoordMax);
    add_row(tchc_pkg::OP_TEST, -9, 3, 40, 1, tchc_pkg::ClassOutside, 4'hf, 3'd4, 0);
    // Clear in the middle of a cell keeps the cell progress.
    add_row(tchc_pkg::OP_TEST, 1, 1, -5);
    add_row(tchc_pkg::OP_TEST, 1, 1, CoordMax);
    add_row(tchc_pkg::OP_CLEAR, 0, 0, 0);
    add_row(tchc_pkg::OP_TEST, 1, 1, 1);
    add_row(tchc_pkg::OP_TEST, 1, 1, CoordMin, 1, tchc_pkg::ClassMixed, 4'h2, 3'd1, 0);
    // Degenerate facet at the extreme corner never marks anything.
    add_row(tchc_pkg::OP_LOAD, CoordMax, CoordMax, CoordMax);
    add_row(tchc_pkg::OP_LOAD, CoordMax, CoordMax, CoordMax);
    add_row(tchc_pkg::OP_LOAD, CoordMax, CoordMax, CoordMax);
    add_row(tchc_pkg::OP_TEST, CoordMin, 0, 7);
    add_row(tchc_pkg::OP_TEST, 3, CoordMax, -7);
    add_row(tchc_pkg::OP_TEST, 0, 0, CoordMin);
    add_row(tchc_pkg::OP_TEST, CoordMax, 1, 1);
    foreach (rows[i]) begin
      maybe_idle(1);
      issue(rows[i].op, rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].v);
    end

    // Random mix of clears, hull loads and cell tests; the table stays small.
    n = 0;
    while (n < RandItems) begin
      maybe_idle(n < RandItems - QuietTail);
      r = $urandom_range(0, 99);
      if (facet_total > 8 || r < 4) op = tchc_pkg::OP_CLEAR;
      else if (r < 8) op = tchc_pkg::OP_NONE;
      else if (r < 42) op = tchc_pkg::OP_LOAD;
      else op = tchc_pkg::OP_TEST;
      issue(op, rand_coord(), rand_coord(), rand_coord(), 0, '0);
      if (op != tchc_pkg::OP_NONE) n++;
    end

    // A clear and a few more tests against the empty table.
    issue(tchc_pkg::OP_CLEAR, 0, 0, 0, 0, '0);
    repeat (4) issue(tchc_pkg::OP_TEST, rand_coord(), rand_coord(), rand_coord(), 0, '0);
    start_i <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (Facets + 20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tetra_cell_hull_classifier_tb: done, clean");
    end else begin
      $display("tetra_cell_hull_classifier_tb: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #25ms;
    $display("tetra_cell_hull_classifier_tb: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tchc_pkg.sv
design/tchc_dot_pipe.sv
design/tetra_cell_hull_classifier.sv
tb/tetra_cell_hull_classifier_tb.sv
